[src/sorted_rank_list_core_macros.svh]
// Assertion macros used by the checker file.
`ifndef SORTED_RANK_LIST_CORE_MACROS_SVH
`define SORTED_RANK_LIST_CORE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define SRLC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted_rank_list_core: assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define SRLC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted_rank_list_core: assertion failed");

`endif

[src/srl_pkg.sv]
`default_nettype none

package srl_pkg;

    localparam int SCORE_W = 32;
    localparam int TAG_W   = 32;
    localparam int RANK_W  = 5;
    localparam int COUNT_W = 5;

    typedef logic signed [SCORE_W-1:0] t_score;
    typedef logic [TAG_W-1:0]          t_tag;
    typedef logic [RANK_W-1:0]         t_rank;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    typedef enum logic [2:0] {
        STAT_INSERTED  = 3'd0,
        STAT_DUPLICATE = 3'd1,
        STAT_FULL      = 3'd2,
        STAT_FOUND     = 3'd3,
        STAT_EMPTY     = 3'd4
    } t_status;

    typedef enum logic {
        ST_IDLE  = 1'b0,
        ST_APPLY = 1'b1
    } t_state;

    typedef struct packed {
        t_score score;
        t_tag   tag;
    } t_entry;

    typedef struct packed {
        logic   command;
        t_score score;
        t_tag   payload_tag;
    } t_in_item;

    typedef struct packed {
        t_status              status;
        t_score               found_score;
        t_tag                 found_tag;
        logic [COUNT_W-1:0]   entry_count;
    } t_out_item;

    // Per-cell flags, sampled while the item is taken in.
    typedef struct packed {
        logic ins;
        logic eq;
        logic hit;
    } t_cell_flags;

endpackage

`default_nettype wire

[src/srl_cell.sv]
`default_nettype none

module srl_cell #(
    parameter int IDX = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_capture,
    input  logic                 i_commit,
    input  srl_pkg::t_score      i_key,
    input  srl_pkg::t_rank       i_rank_idx,
    input  srl_pkg::t_entry      i_new,
    input  srl_pkg::t_entry      i_prev,
    input  logic                 i_prev_valid,
    input  logic                 i_prev_ins,
    output srl_pkg::t_entry      o_entry,
    output logic                 o_valid,
    output srl_pkg::t_cell_flags o_flags
);
    import srl_pkg::*;

    logic        r_valid;
    t_entry      r_entry;
    t_cell_flags r_flags;
    t_cell_flags n_flags;

    // An empty cell or a lower score marks where the new entry goes or below.
    always_comb begin
        n_flags.ins = !r_valid || (r_entry.score < i_key);
        n_flags.eq  = r_valid && (r_entry.score == i_key);
        n_flags.hit = r_valid && (IDX == int'(i_rank_idx));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_flags <= '0;
        end else begin
            if (i_capture) begin
                r_flags <= n_flags;
            end
            if (i_commit) begin
                priority if (i_prev_ins) begin
                    r_valid <= i_prev_valid;
                end else if (r_flags.ins) begin
                    r_valid <= 1'b1;
                end else begin
                    r_valid <= r_valid;
                end
            end
        end
    end

    // Shift down from the neighbor above, or take the new entry at the split.
    always_ff @(posedge i_clk) begin
        if (i_commit) begin
            priority if (i_prev_ins) begin
                r_entry <= i_prev;
            end else if (r_flags.ins) begin
                r_entry <= i_new;
            end else begin
                r_entry <= r_entry;
            end
        end
    end

    assign o_entry = r_entry;
    assign o_valid = r_valid;
    assign o_flags = r_flags;

endmodule

`default_nettype wire

[src/sorted_rank_list_core.sv]
// Items are taken one at a time: no new item is accepted until the result of the
// last one is loaded into the output register. Taking an item in samples the
// per-cell compare flags; the apply state then commits the shift along the cell
// chain and loads the result. A stalled output holds the apply state.
// Reset (synchronous, active low) empties the list, clears the entry count and
// sets the rank register to 1. Configuration writes are taken every cycle.
`default_nettype none

module sorted_rank_list_core #(
    parameter int CAPACITY = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  srl_pkg::t_rank     i_cfg_win_rank,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  srl_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output srl_pkg::t_out_item o_out_item
);
    import srl_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    t_state             r_state, n_state;
    t_in_item           r_item;
    t_rank              r_win_rank;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_out_valid, n_out_valid;
    t_out_item          r_out, n_out;

    logic               w_capture;
    logic               w_commit;
    logic               w_apply;
    t_rank              w_rank_idx;
    t_entry             w_new;
    t_entry             w_entry [CAPACITY];
    logic [CAPACITY-1:0] w_valid;
    t_cell_flags        w_flags [CAPACITY];
    logic               w_dup;
    logic               w_full;
    logic               w_found;
    t_entry             w_found_entry;

    assign w_rank_idx = (r_win_rank == '0) ? '0 : r_win_rank - t_rank'(1);
    assign w_new      = '{score: r_item.score, tag: r_item.payload_tag};
    assign w_capture  = i_in_valid && o_in_ready;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            t_entry w_prev;
            logic   w_prev_valid;
            logic   w_prev_ins;
            if (gi == 0) begin : g_head
                assign w_prev       = w_new;
                assign w_prev_valid = 1'b0;
                assign w_prev_ins   = 1'b0;
            end else begin : g_body
                assign w_prev       = w_entry[gi-1];
                assign w_prev_valid = w_valid[gi-1];
                assign w_prev_ins   = w_flags[gi-1].ins;
            end
            srl_cell #(
                .IDX (gi)
            ) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_capture    (w_capture),
                .i_commit     (w_commit),
                .i_key        (i_in_item.score),
                .i_rank_idx   (w_rank_idx),
                .i_new        (w_new),
                .i_prev       (w_prev),
                .i_prev_valid (w_prev_valid),
                .i_prev_ins   (w_prev_ins),
                .o_entry      (w_entry[gi]),
                .o_valid      (w_valid[gi]),
                .o_flags      (w_flags[gi])
            );
        end
    endgenerate

    // Gather duplicate and rank hit across the chain; at most one cell hits.
    always_comb begin
        w_dup         = 1'b0;
        w_found       = 1'b0;
        w_found_entry = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_dup         = w_dup | w_flags[i].eq;
            w_found       = w_found | w_flags[i].hit;
            w_found_entry = w_found_entry | (w_flags[i].hit ? w_entry[i] : '0);
        end
    end

    assign w_full = (r_count == CNT_W'(CAPACITY));

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        o_in_ready  = 1'b0;
        w_apply     = 1'b0;
        w_commit    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = ST_APPLY;
                end
            end
            ST_APPLY: begin
                // Hold until the output register is free or being drained.
                w_apply = !r_out_valid || i_out_ready;
                if (w_apply) begin
                    n_state           = ST_IDLE;
                    n_out_valid       = 1'b1;
                    n_out.found_score = '0;
                    n_out.found_tag   = '0;
                    if (r_item.command == CMD_INSERT) begin
                        priority if (w_dup) begin
                            n_out.status = STAT_DUPLICATE;
                        end else if (w_full) begin
                            n_out.status = STAT_FULL;
                        end else begin
                            n_out.status = STAT_INSERTED;
                            w_commit     = 1'b1;
                            n_count      = r_count + CNT_W'(1);
                        end
                    end else if (w_found) begin
                        n_out.status      = STAT_FOUND;
                        n_out.found_score = w_found_entry.score;
                        n_out.found_tag   = w_found_entry.tag;
                    end else begin
                        n_out.status = STAT_EMPTY;
                    end
                    n_out.entry_count = COUNT_W'(n_count);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_win_rank  <= t_rank'(1);
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_win_rank <= i_cfg_win_rank;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_capture) begin
            r_item <= i_in_item;
        end
        if (w_apply) begin
            r_out <= n_out;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

`default_nettype wire

[src/sorted_rank_list_core_chk.sv]
`default_nettype none

`include "sorted_rank_list_core_macros.svh"

module sorted_rank_list_core_chk #(
    parameter int CAPACITY = 16
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input srl_pkg::t_out_item o_out_item
);
    import srl_pkg::*;

    logic w_in_xfer;
    logic w_no_data;
    logic w_count_ok;

    assign w_in_xfer  = i_in_valid && o_in_ready;
    assign w_no_data  = (o_out_item.status != STAT_FOUND);
    assign w_count_ok = (CAPACITY > 31) || (int'(o_out_item.entry_count) <= CAPACITY);

    // Hold a stalled result.
    `SRLC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)
    // One item in flight: no transfer right after a transfer.
    `SRLC_ASSERT_NEXT(a_in_gap, i_clk, i_rst_n, w_in_xfer, !o_in_ready)
    // Only a found rank carries entry data.
    `SRLC_ASSERT_NOW(a_zero_data, i_clk, i_rst_n, o_out_valid && w_no_data,
        o_out_item.found_score == '0 && o_out_item.found_tag == '0)
    `SRLC_ASSERT_NOW(a_count_cap, i_clk, i_rst_n, o_out_valid, w_count_ok)

endmodule

bind sorted_rank_list_core sorted_rank_list_core_chk #(.CAPACITY(CAPACITY)) u_chk (.*);

`default_nettype wire
